>>> sv/prp_frame_builder_top_assert.svh
// Assertion macros shared by the RTL files. They expect clk and rst_n in scope.
`ifndef PRP_FRAME_BUILDER_TOP_ASSERT_SVH
`define PRP_FRAME_BUILDER_TOP_ASSERT_SVH

// Condition holds at every edge out of reset.
`define PRP_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next.
`define PRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/prp_pkg.sv
package prp_pkg;

  localparam int MIN_PAYLOAD   = 42;
  localparam int MAX_PAYLOAD   = 1500;
  localparam int TRAILER_BYTES = 4;
  localparam int LEN_W         = 12;

  localparam logic [LEN_W-1:0] KEEP_MAX  = LEN_W'(MAX_PAYLOAD - TRAILER_BYTES);
  localparam logic [LEN_W-1:0] KEEP_MIN  = LEN_W'(MIN_PAYLOAD);

  // Command queue geometry
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  // Byte index within one command
  localparam int IDX_W = 4;
  localparam logic [IDX_W-1:0] HDR_LAST_IDX = 4'd13;
  localparam logic [IDX_W-1:0] TRL_LAST_IDX = 4'd4;

  // Register indexes
  localparam logic [1:0] CFG_SOURCE_MAC = 2'd0;
  localparam logic [1:0] CFG_DEST_MAC   = 2'd1;
  localparam logic [1:0] CFG_ETHERTYPE  = 2'd2;

  // Input word kinds
  localparam logic REQ_START   = 1'b0;
  localparam logic REQ_PAYLOAD = 1'b1;

  // Result status codes
  localparam logic ST_OK    = 1'b0;
  localparam logic ST_SHORT = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PASS = 2'd1,
    PH_DROP = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    CMD_HDR  = 2'd0,
    CMD_ERR  = 2'd1,
    CMD_DATA = 2'd2,
    CMD_LAST = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [7:0]       data;
    logic [15:0]      seq;
    logic [3:0]       lan;
    logic [LEN_W-1:0] size;
  } cmd_t;

  typedef struct packed {
    logic [47:0] source_mac;
    logic [47:0] dest_mac;
    logic [15:0] ethertype;
  } cfg_t;

endpackage

>>> sv/prp_front.sv
module prp_front
  import prp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc,
  input  logic             req_type,
  input  logic [LEN_W-1:0] payload_length,
  input  logic [15:0]      sequence_number,
  input  logic [3:0]       lan_nibble,
  input  logic [7:0]       data_byte,
  output logic             push,
  output cmd_t             push_cmd
);

  phase_t           phase_r, phase_nxt;
  logic [LEN_W-1:0] remain_r, remain_nxt;
  logic [LEN_W-1:0] kept_len_r, kept_len_nxt;
  logic [LEN_W-1:0] kept_cnt_r, kept_cnt_nxt;
  logic [15:0]      seq_r, seq_nxt;
  logic [3:0]       lan_r, lan_nxt;

  logic [LEN_W-1:0] clamp_len;
  logic [LEN_W-1:0] remain_dec;
  logic [LEN_W-1:0] kept_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      remain_r   <= '0;
      kept_len_r <= '0;
      kept_cnt_r <= '0;
      seq_r      <= '0;
      lan_r      <= '0;
    end else begin
      phase_r    <= phase_nxt;
      remain_r   <= remain_nxt;
      kept_len_r <= kept_len_nxt;
      kept_cnt_r <= kept_cnt_nxt;
      seq_r      <= seq_nxt;
      lan_r      <= lan_nxt;
    end
  end

  always_comb begin
    clamp_len  = (payload_length > KEEP_MAX) ? KEEP_MAX : payload_length;
    remain_dec = (remain_r != '0) ? remain_r - LEN_W'(1) : remain_r;
    kept_inc   = kept_cnt_r + LEN_W'(1);

    phase_nxt    = phase_r;
    remain_nxt   = remain_r;
    kept_len_nxt = kept_len_r;
    kept_cnt_nxt = kept_cnt_r;
    seq_nxt      = seq_r;
    lan_nxt      = lan_r;

    push          = 1'b0;
    push_cmd.kind = CMD_DATA;
    push_cmd.data = data_byte;
    push_cmd.seq  = seq_r;
    push_cmd.lan  = lan_r;
    push_cmd.size = kept_len_r;

    if (acc) begin
      if (req_type == REQ_START) begin
        seq_nxt      = sequence_number;
        lan_nxt      = lan_nibble;
        remain_nxt   = payload_length;
        kept_cnt_nxt = '0;
        push         = 1'b1;
        if (clamp_len < KEEP_MIN) begin
          kept_len_nxt  = '0;
          phase_nxt     = (payload_length != '0) ? PH_DROP : PH_IDLE;
          push_cmd.kind = CMD_ERR;
        end else begin
          kept_len_nxt  = clamp_len;
          phase_nxt     = PH_PASS;
          push_cmd.kind = CMD_HDR;
        end
      end else begin
        case (phase_r)
          PH_PASS: begin
            remain_nxt   = remain_dec;
            kept_cnt_nxt = kept_inc;
            push         = 1'b1;
            if (kept_inc >= kept_len_r) begin
              push_cmd.kind = CMD_LAST;
              phase_nxt     = (remain_dec != '0) ? PH_DROP : PH_IDLE;
            end
          end
          PH_DROP: begin
            remain_nxt = remain_dec;
            if (remain_dec == '0) phase_nxt = PH_IDLE;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

>>> sv/prp_cmd_fifo.sv
module prp_cmd_fifo
  import prp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic empty,
  output logic full
);
`include "prp_frame_builder_top_assert.svh"

  cmd_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0] count_r, count_nxt;

  assign empty = (count_r == '0);
  assign full  = (count_r == FIFO_CW'(FIFO_DEPTH));
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + FIFO_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + FIFO_AW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) count_nxt = count_r + FIFO_CW'(1);
    if (pop && !push) count_nxt = count_r - FIFO_CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_cmd;
  end

  `PRP_ASSERT_ALWAYS(a_no_push_full, !(push && full), "push into full queue")
  `PRP_ASSERT_ALWAYS(a_no_pop_empty, !(pop && empty), "pop from empty queue")
  `PRP_ASSERT_NEXT(a_count_up, push && !pop, count_r == $past(count_r) + FIFO_CW'(1),
                   "queue count did not rise on push")

endmodule

>>> sv/prp_back.sv
module prp_back
  import prp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  cmd_t       head,
  input  logic       empty,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_frame_end,
  output logic       out_status
);
`include "prp_frame_builder_top_assert.svh"

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             valid_r, valid_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic             end_r, end_nxt;
  logic             status_r, status_nxt;

  logic             load;
  logic [IDX_W-1:0] last_idx;
  logic [7:0]       sel_byte;
  logic             sel_end;
  logic             sel_status;

  assign out_valid     = valid_r;
  assign out_byte      = byte_r;
  assign out_frame_end = end_r;
  assign out_status    = status_r;

  // Byte of the head command at the current index
  always_comb begin
    sel_byte   = 8'h00;
    sel_end    = 1'b0;
    sel_status = ST_OK;
    last_idx   = '0;
    case (head.kind)
      CMD_HDR: begin
        last_idx = HDR_LAST_IDX;
        case (idx_r)
          4'd0:    sel_byte = cfg.dest_mac[47:40];
          4'd1:    sel_byte = cfg.dest_mac[39:32];
          4'd2:    sel_byte = cfg.dest_mac[31:24];
          4'd3:    sel_byte = cfg.dest_mac[23:16];
          4'd4:    sel_byte = cfg.dest_mac[15:8];
          4'd5:    sel_byte = cfg.dest_mac[7:0];
          4'd6:    sel_byte = cfg.source_mac[47:40];
          4'd7:    sel_byte = cfg.source_mac[39:32];
          4'd8:    sel_byte = cfg.source_mac[31:24];
          4'd9:    sel_byte = cfg.source_mac[23:16];
          4'd10:   sel_byte = cfg.source_mac[15:8];
          4'd11:   sel_byte = cfg.source_mac[7:0];
          4'd12:   sel_byte = cfg.ethertype[15:8];
          default: sel_byte = cfg.ethertype[7:0];
        endcase
      end
      CMD_ERR: begin
        sel_end    = 1'b1;
        sel_status = ST_SHORT;
      end
      CMD_DATA: sel_byte = head.data;
      CMD_LAST: begin
        last_idx = TRL_LAST_IDX;
        case (idx_r)
          4'd0:    sel_byte = head.data;
          4'd1:    sel_byte = head.seq[15:8];
          4'd2:    sel_byte = head.seq[7:0];
          4'd3:    sel_byte = {head.lan, head.size[11:8]};
          default: begin
            sel_byte = head.size[7:0];
            sel_end  = 1'b1;
          end
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    load       = !valid_r || !out_stall;
    pop        = 1'b0;
    idx_nxt    = idx_r;
    valid_nxt  = valid_r;
    byte_nxt   = byte_r;
    end_nxt    = end_r;
    status_nxt = status_r;
    if (load) begin
      valid_nxt = !empty;
      if (!empty) begin
        byte_nxt   = sel_byte;
        end_nxt    = sel_end;
        status_nxt = sel_status;
        if (idx_r == last_idx) begin
          pop     = 1'b1;
          idx_nxt = '0;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r   <= byte_nxt;
    end_r    <= end_nxt;
    status_r <= status_nxt;
  end

  `PRP_ASSERT_ALWAYS(a_idx_range, idx_r <= HDR_LAST_IDX, "byte index past header end")
  `PRP_ASSERT_ALWAYS(a_pop_nonempty, !(pop && empty), "pop with no command queued")
  `PRP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(out_frame_end) && $stable(out_status), "stalled result word changed")

endmodule

>>> sv/prp_frame_builder_top.sv
// Each command that an accepted word posts is written into the command queue; its first
// result byte is then loaded from the queue head into the output register once that register is free.
// Throughput: one input word per cycle while the queue is not full; header (14 bytes)
// and last payload byte plus trailer (5 bytes) bursts drain one byte per cycle while
// out_stall is low, and back-pressure the input via the 4-entry command queue.
// Reset: synchronous active-low rst_n clears phase, counters, queue, output valid and
// all config registers (MACs and ethertype read as zero until written).
module prp_frame_builder_top
  import prp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // input word channel
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_req_type,
  input  logic [LEN_W-1:0] in_payload_length,
  input  logic [15:0]      in_sequence_number,
  input  logic [3:0]       in_lan_nibble,
  input  logic [7:0]       in_data_byte,
  // result channel
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic             out_frame_end,
  output logic             out_status,
  // config write channel
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [47:0]      cfg_data
);

  cfg_t cfg_r, cfg_nxt;

  logic in_acc;
  logic push;
  cmd_t push_cmd;
  logic pop;
  cmd_t head;
  logic empty;
  logic full;

  // Config registers are always writable; host writes must come only while the block is idle (unenforced).
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_SOURCE_MAC: cfg_nxt.source_mac = cfg_data;
        CFG_DEST_MAC:   cfg_nxt.dest_mac   = cfg_data;
        CFG_ETHERTYPE:  cfg_nxt.ethertype  = cfg_data[15:0];
        default: ;      // unmapped index: ignore
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front stalls only when the command queue is full.
  assign in_stall = full;
  assign in_acc   = in_valid && !full;

  // Front: tracks frame phase and byte counts, posts at most one command per word (none for dropped words).
  prp_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .acc             (in_acc),
    .req_type        (in_req_type),
    .payload_length  (in_payload_length),
    .sequence_number (in_sequence_number),
    .lan_nibble      (in_lan_nibble),
    .data_byte       (in_data_byte),
    .push            (push),
    .push_cmd        (push_cmd)
  );

  // Queue decouples word intake from byte emission.
  prp_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  // Back: expands each command into header, payload, trailer or error bytes.
  prp_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .head          (head),
    .empty         (empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_frame_end (out_frame_end),
    .out_status    (out_status)
  );

endmodule
